// File: rtl/bba_pkg.sv
// shared types, constants and controller/datapath handshake structs for the bitmap allocator
`default_nettype none
package bba_pkg;

  localparam int DEF_MAX_BITS  = 32768;
  localparam int DEF_WORD_BITS = 32;

  // positions and indices are 15 bits wide, so the usable span stops here
  localparam int ADDR_SPAN = 32768;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 15;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 16;
  // scan base runs one word past the limit at most
  localparam int BASE_W = POS_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic    cap;
    logic    clr;
    logic    scan_init;
    logic    scan_step;
    logic    rw_issue;
    logic    rw_apply;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    cmd_t cmd;
    logic in_range;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/bba_if.sv
// request and result channel interfaces of the bitmap allocator
`default_nettype none
interface bba_in_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic             bit_in;

  modport source (output valid, output command, output position, output bit_in,
                  input ready);
  modport sink (input valid, input command, input position, input bit_in,
                output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic              bit_out;
  logic [POS_W-1:0]  allocated_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, output bit_out, output allocated_index, output status,
                  input ready);
  modport sink (input valid, input bit_out, input allocated_index, input status,
                output ready);
endinterface
`default_nettype wire

// File: rtl/bba_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/bba_ctrl.sv
// controller state machine of the bitmap allocator
`default_nettype none
module bba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bba_pkg::dp_stat_t  st,
  output bba_pkg::dp_cmd_t        cmd
);
  import bba_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_ADDR   = 7'b0001000,
    S_APPLY  = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.cmd) inside
          CMD_READ, CMD_WRITE: begin
            if (st.in_range) begin
              state_nxt = S_ADDR;
            end else begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_RANGE;
              state_nxt      = S_RESP;
            end
          end
          CMD_FIND: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          default: begin
            // no-operation code answers ok with zero fields
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_ADDR: begin
        cmd.rw_issue = 1'b1;
        state_nxt    = S_APPLY;
      end
      S_APPLY: begin
        cmd.rw_apply = 1'b1;
        state_nxt    = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit || st.exhausted) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request did not move to decode");

  a_scan_end_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && (st.hit || st.exhausted)) |=> (state_r == S_RESP))
    else $error("finished scan did not move to response");
`endif

endmodule
`default_nettype wire

// File: rtl/bba_dp.sv
// datapath of the bitmap allocator: bitmap ram, word/bit split, scan pipeline, result regs
`default_nettype none
module bba_dp #(
  parameter int MAX_BITS  = bba_pkg::DEF_MAX_BITS,
  parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bba_pkg::dp_cmd_t            cmd,
  output bba_pkg::dp_stat_t                stat,
  input  wire logic [bba_pkg::CMD_W-1:0]   req_command,
  input  wire logic [bba_pkg::POS_W-1:0]   req_position,
  input  wire logic                        req_bit_in,
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic                             res_bit_out,
  output logic [bba_pkg::POS_W-1:0]        res_allocated_index,
  output logic [bba_pkg::STAT_W-1:0]       res_status
);
  import bba_pkg::*;

  localparam int NWORDS   = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIX_W    = $clog2(WORD_BITS);
  localparam int NCNT_W   = $clog2(WORD_BITS + 1);
  localparam int LIM_CAP  = (MAX_BITS < ADDR_SPAN) ? MAX_BITS : ADDR_SPAN;
  // word index by reciprocal multiply, exact for every 15-bit position
  localparam int RECIP_SH = POS_W + BIX_W;
  localparam int RECIP_M  = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;

  logic [CFG_W-1:0]     lim_r;
  cmd_t                 cmd_r;
  logic [POS_W-1:0]     pos_r;
  logic                 bit_r;
  logic [POS_W-1:0]     q_r;
  logic [BIX_W-1:0]     rem_r;
  logic [AW-1:0]        clr_addr_r;

  logic [AW-1:0]        iss_addr_r;
  logic [BASE_W-1:0]    iss_base_r;
  logic                 ev_valid_r;
  logic [AW-1:0]        ev_addr_r;
  logic [BASE_W-1:0]    ev_base_r;
  logic [NCNT_W-1:0]    ev_n_r;

  logic                 rb_bit_r;
  logic [POS_W-1:0]     rb_idx_r;
  status_t              rb_status_r;
  logic                 out_valid_r;
  logic                 out_bit_r;
  logic [POS_W-1:0]     out_idx_r;
  status_t              out_status_r;

  logic [31:0]          recip_prod;
  logic [31:0]          word_start;
  logic                 iss_ok;
  logic [BASE_W-1:0]    iss_room;
  logic [NCNT_W-1:0]    n_nxt;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] free_w;
  logic [BIX_W-1:0]     pri;
  logic                 hit;
  logic                 exhausted;
  logic [WORD_BITS-1:0] wr_word;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [BASE_W-1:0]    hit_idx;

  assign recip_prod = 32'(pos_r) * 32'(RECIP_M);
  assign word_start = 32'(q_r) * 32'(WORD_BITS);

  // limit register holds bitmap_bits already capped to the usable span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= CFG_W'(LIM_CAP);
    end else if (cfg_we) begin
      lim_r <= (cfg_wdata > CFG_W'(LIM_CAP)) ? CFG_W'(LIM_CAP) : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r <= cmd_t'(req_command);
      pos_r <= req_position;
      bit_r <= req_bit_in;
    end
    q_r   <= POS_W'(recip_prod >> RECIP_SH);
    rem_r <= BIX_W'(pos_r - POS_W'(word_start));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // scan: issue stage reads one word a cycle, eval stage looks at the word read last cycle
  assign iss_ok   = (iss_base_r < BASE_W'(lim_r));
  assign iss_room = BASE_W'(lim_r) - iss_base_r;
  assign n_nxt    = (iss_room >= BASE_W'(WORD_BITS)) ? NCNT_W'(WORD_BITS) : NCNT_W'(iss_room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (cmd.scan_init) begin
      ev_valid_r <= 1'b0;
    end else if (cmd.scan_step) begin
      ev_valid_r <= iss_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      iss_addr_r <= '0;
      iss_base_r <= '0;
    end else if (cmd.scan_step) begin
      ev_addr_r <= iss_addr_r;
      ev_base_r <= iss_base_r;
      ev_n_r    <= n_nxt;
      if (iss_ok) begin
        iss_addr_r <= iss_addr_r + AW'(1);
        iss_base_r <= iss_base_r + BASE_W'(WORD_BITS);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_w[b] = ~rdata[b] & (NCNT_W'(b) < ev_n_r);
    end
  end

  // lowest free bit wins
  always_comb begin
    pri = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_w[b]) begin
        pri = BIX_W'(b);
      end
    end
  end

  assign hit       = cmd.scan_step && ev_valid_r && (|free_w);
  assign exhausted = cmd.scan_step && !ev_valid_r && !iss_ok;
  assign hit_idx   = ev_base_r + BASE_W'(pri);

  always_comb begin
    wr_word        = rdata;
    wr_word[rem_r] = bit_r;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(q_r);
    ram_wdata = wr_word;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (hit) begin
      ram_we    = 1'b1;
      ram_waddr = ev_addr_r;
      ram_wdata = rdata | (WORD_BITS'(1) << pri);
    end else if (cmd.rw_apply && cmd_r == CMD_WRITE) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd.scan_step || cmd.rw_issue;
  assign ram_raddr = cmd.scan_step ? iss_addr_r : AW'(q_r);

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // result staging, then the output register that faces the sink
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      rb_bit_r    <= 1'b0;
      rb_idx_r    <= '0;
      rb_status_r <= cmd.res_status;
    end else if (cmd.rw_apply) begin
      rb_bit_r    <= (cmd_r == CMD_READ) ? rdata[rem_r] : 1'b0;
      rb_idx_r    <= '0;
      rb_status_r <= ST_OK;
    end else if (hit) begin
      rb_bit_r    <= 1'b0;
      rb_idx_r    <= POS_W'(hit_idx);
      rb_status_r <= ST_OK;
    end else if (exhausted) begin
      rb_bit_r    <= 1'b0;
      rb_idx_r    <= '0;
      rb_status_r <= ST_NO_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bit_r    <= rb_bit_r;
      out_idx_r    <= rb_idx_r;
      out_status_r <= rb_status_r;
    end
  end

  assign res_valid           = out_valid_r;
  assign res_bit_out         = out_bit_r;
  assign res_allocated_index = out_idx_r;
  assign res_status          = out_status_r;

  assign stat.clr_done  = (clr_addr_r == AW'(NWORDS - 1));
  assign stat.cmd       = cmd_r;
  assign stat.in_range  = ({1'b0, pos_r} < lim_r);
  assign stat.hit       = hit;
  assign stat.exhausted = exhausted;
  assign stat.out_free  = !out_valid_r || res_ready;

`ifndef SYNTH
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || res_ready))
    else $error("result loaded over one not yet taken");

  a_scan_writes_on_hit_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && cmd.scan_step) |-> hit)
    else $error("bitmap written during scan without a hit");

  a_hit_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (hit_idx < BASE_W'(lim_r)))
    else $error("allocated bit at or beyond the limit");
`endif

endmodule
`default_nettype wire

// File: rtl/bitmap_block_allocator_unit.sv
// top level of the first-fit bitmap block allocator
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    command, position, bit_in
//  out_ch    out  valid / ready    bit_out, allocated_index, status
//  cfg_*     in   cfg_we only      cfg_wdata = bitmap_bits
//
//  read or write: decode, address and apply states, then response; no-op or out of range:
//  decode straight to response; find: one ram word read per cycle through the scan
//  pipeline from word 0 up to the limit, ending at the first free bit or when exhausted
//  after reset a clearing pass writes zero to every ram word before the first request
//  is taken; configuration writes are taken at any time
//  a stalled result sits in the output register while the next request is processed
`default_nettype none
module bitmap_block_allocator_unit #(
  parameter int MAX_BITS  = bba_pkg::DEF_MAX_BITS,
  parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bba_in_if.sink                         in_ch,
  bba_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [bba_pkg::CFG_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (dp_stat),
    .cmd      (dp_cmd)
  );

  bba_dp #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (dp_cmd),
    .stat                (dp_stat),
    .req_command         (in_ch.command),
    .req_position        (in_ch.position),
    .req_bit_in          (in_ch.bit_in),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .res_valid           (out_ch.valid),
    .res_ready           (out_ch.ready),
    .res_bit_out         (out_ch.bit_out),
    .res_allocated_index (out_ch.allocated_index),
    .res_status          (out_ch.status)
  );

endmodule
`default_nettype wire

// File: verif/bba_reply_checker.sv
`timescale 1ns / 100ps
// predicts and checks the replies of the bitmap allocator from its request and result channels
module bba_reply_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  bba_in_if                         in_mon,
  bba_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata,
  output int                        pending_count,
  output int                        mismatch_count
);
  import bba_pkg::*;

  typedef struct packed {
    logic             bit_out;
    logic [POS_W-1:0] index;
    status_t          status;
  } alloc_reply_t;

  bit [ADDR_SPAN-1:0] usage_map;
  logic [CFG_W-1:0]   bitmap_limit = 16'd32768;
  alloc_reply_t       replies_due[$];
  int                 errors = 0;

  // applies one request to the local bitmap and returns the reply it should give
  function automatic alloc_reply_t predict_reply(input cmd_t cmd, input logic [POS_W-1:0] pos,
                                                 input logic bit_val);
    alloc_reply_t reply;
    int unsigned  span;
    int unsigned  k;
    bit           found;
    reply = '{bit_out: 1'b0, index: '0, status: ST_OK};
    span  = (bitmap_limit > ADDR_SPAN) ? ADDR_SPAN : bitmap_limit;
    found = 1'b0;
    case (cmd)
      CMD_READ: begin
        if (pos < span) reply.bit_out = usage_map[pos];
        else reply.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (pos < span) usage_map[pos] = bit_val;
        else reply.status = ST_RANGE;
      end
      CMD_FIND: begin
        for (k = 0; k < span && !found; k++) begin
          if (!usage_map[k]) begin
            found        = 1'b1;
            usage_map[k] = 1'b1;
            reply.index  = k[POS_W-1:0];
          end
        end
        if (!found) reply.status = ST_NO_FREE;
      end
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t due;
    if (!rst_n) begin
      usage_map    = '0;
      bitmap_limit = 16'd32768;
      replies_due.delete();
    end else begin
      if (cfg_we) bitmap_limit = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        replies_due.push_back(predict_reply(cmd_t'(in_mon.command), in_mon.position,
                                            in_mon.bit_in));
      if (out_mon.valid && out_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: bit_out %0d, allocated_index %0d, status %0d",
                 out_mon.bit_out, out_mon.allocated_index, out_mon.status);
          errors++;
        end else begin
          due = replies_due.pop_front();
          if (out_mon.bit_out !== due.bit_out) begin
            $error("bit_out: expected %0d, actual %0d", due.bit_out, out_mon.bit_out);
            errors++;
          end
          if (out_mon.allocated_index !== due.index) begin
            $error("allocated_index: expected %0d, actual %0d", due.index,
                   out_mon.allocated_index);
            errors++;
          end
          if (out_mon.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_mon.status);
            errors++;
          end
        end
      end
    end
    pending_count  <= replies_due.size();
    mismatch_count <= errors;
  end

endmodule

// File: verif/bitmap_block_allocator_unit_test.sv
`timescale 1ns / 100ps
// stimulus, handshake pacing and verdict for the bitmap allocator
module bitmap_block_allocator_unit_test;
  import bba_pkg::*;

  // random requests after the directed ones
  localparam int RANDOM_ITEMS = 556;
  // clearing pass plus a full scan plus the longest gaps, with plenty to spare
  localparam int STALL_LIMIT  = 20000;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             tx_valid   = 1'b0;
  logic [CMD_W-1:0] tx_command = '0;
  logic [POS_W-1:0] tx_position = '0;
  logic             tx_bit_in  = 1'b0;
  logic             rx_ready   = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [CFG_W-1:0] cfg_wdata  = '0;
  logic             rx_calm    = 1'b0;
  bit               tx_burst   = 1'b0;
  int               stall_left = 0;
  int               pending_count;
  int               mismatch_count;
  int               idle_cycles;

  bba_in_if  req_ch ();
  bba_out_if res_ch ();

  assign req_ch.valid    = tx_valid;
  assign req_ch.command  = tx_command;
  assign req_ch.position = tx_position;
  assign req_ch.bit_in   = tx_bit_in;
  assign res_ch.ready    = rx_ready;

  bitmap_block_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bba_reply_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (req_ch),
    .out_mon        (res_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure, drawn afresh after every reply
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      stall_left <= 0;
      rx_ready   <= 1'b0;
    end else if (res_ch.valid && rx_ready) begin
      draw = rx_calm ? 0 : $urandom_range(0, 18);
      stall_left <= draw;
      rx_ready   <= (draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rx_ready   <= (stall_left == 1);
    end else begin
      rx_ready <= 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((tx_valid && req_ch.ready) || (res_ch.valid && rx_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // valid stays up into the next request when there is no gap
  task automatic send_req(input cmd_t cmd, input logic [POS_W-1:0] pos, input logic bit_val);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      tx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tx_valid    <= 1'b1;
    tx_command  <= cmd;
    tx_position <= pos;
    tx_bit_in   <= bit_val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results();
    tx_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] lim;
    logic [POS_W-1:0] pos;
    cmd_t             cmd;
    int unsigned      eff;
    int unsigned      roll;
    int               items_done;
    int               phase_len;

    items_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // full span straight after reset
    send_req(CMD_READ, 15'd0, 1'b0);
    send_req(CMD_READ, 15'h7fff, 1'b1);
    send_req(CMD_FIND, 15'h7fff, 1'b0);
    send_req(CMD_FIND, 15'd0, 1'b1);
    send_req(CMD_WRITE, 15'h7fff, 1'b1);
    send_req(CMD_READ, 15'h7fff, 1'b0);
    send_req(CMD_WRITE, 15'd1, 1'b0);
    send_req(CMD_FIND, 15'd0, 1'b0);
    send_req(CMD_WRITE, 15'd0, 1'b0);
    send_req(CMD_NOP, 15'h7fff, 1'b1);
    send_req(CMD_FIND, 15'd0, 1'b0);

    // empty span: reads and writes are out of range, find has nothing free
    write_limit(16'd0);
    send_req(CMD_READ, 15'd0, 1'b0);
    send_req(CMD_WRITE, 15'd0, 1'b1);
    send_req(CMD_FIND, 15'd0, 1'b0);
    send_req(CMD_NOP, 15'd0, 1'b0);

    // above the address span the limit is capped
    write_limit(16'hffff);
    send_req(CMD_READ, 15'h7fff, 1'b0);
    send_req(CMD_WRITE, 15'h7fff, 1'b0);
    send_req(CMD_FIND, 15'd0, 1'b0);

    write_limit(16'd3);
    send_req(CMD_FIND, 15'd0, 1'b0);
    send_req(CMD_READ, 15'd3, 1'b0);
    send_req(CMD_WRITE, 15'd2, 1'b0);
    send_req(CMD_FIND, 15'd0, 1'b0);
    send_req(CMD_FIND, 15'd0, 1'b0);
    send_req(CMD_WRITE, 15'd3, 1'b1);

    while (items_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: lim = CFG_W'($urandom_range(1, 96));
        5: lim = CFG_W'($urandom_range(1, 4) * 32 + $urandom_range(0, 2) - 1);
        6: begin
          case ($urandom_range(0, 4))
            0: lim = 16'd0;
            1: lim = 16'd1;
            2: lim = 16'd32767;
            3: lim = 16'd32768;
            default: lim = 16'hffff;
          endcase
        end
        7: lim = CFG_W'($urandom_range(0, 65535));
        default: lim = CFG_W'($urandom_range(97, 2048));
      endcase
      write_limit(lim);
      eff       = (lim > ADDR_SPAN) ? ADDR_SPAN : lim;
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_calm  <= ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      if (phase_len > RANDOM_ITEMS - items_done) phase_len = RANDOM_ITEMS - items_done;
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) cmd = CMD_FIND;
        else if (roll < 65) cmd = CMD_WRITE;
        else if (roll < 93) cmd = CMD_READ;
        else cmd = CMD_NOP;
        roll = $urandom_range(0, 9);
        if (roll < 7 && eff != 0) pos = POS_W'($urandom_range(0, eff - 1));
        else if (roll < 8 && eff != 0) pos = POS_W'($urandom_range(eff - 1, eff));
        else pos = POS_W'($urandom_range(0, 32767));
        send_req(cmd, pos, 1'($urandom_range(0, 1)));
        items_done++;
        // now and then let every reply come home before going on
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
